// ----- hdl/brc_pkg.sv -----
package brc_pkg;

    localparam int CW = 16;
    localparam int EW = 15;
    localparam int DW = 30;
    localparam int NW = 2 * EW;
    localparam int QW = EW;
    localparam int SW = 16;

    typedef enum logic [1:0] {
        ST_DRAW      = 2'd0,
        ST_SRC_EMPTY = 2'd1,
        ST_DST_EMPTY = 2'd2,
        ST_HIDDEN    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CFG_VIEW_WIDTH  = 3'd0,
        CFG_VIEW_HEIGHT = 3'd1,
        CFG_SCALE_X     = 3'd2,
        CFG_SCALE_Y     = 3'd3,
        CFG_HIDDEN      = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [EW-1:0] view_width;
        logic [EW-1:0] view_height;
        logic [SW-1:0] scale_x;
        logic [SW-1:0] scale_y;
        logic          hidden;
    } cfg_t;

    typedef struct packed {
        logic                 src_given;
        logic signed [CW-1:0] src_x;
        logic signed [CW-1:0] src_y;
        logic signed [CW-1:0] src_w;
        logic signed [CW-1:0] src_h;
        logic                 dst_given;
        logic signed [CW-1:0] dst_x;
        logic signed [CW-1:0] dst_y;
        logic signed [CW-1:0] dst_w;
        logic signed [CW-1:0] dst_h;
        logic [EW-1:0]        tex_width;
        logic [EW-1:0]        tex_height;
    } req_t;

    // one restoring divide in flight: partial remainder and quotient so far
    typedef struct packed {
        logic [NW-1:0] rem;
        logic [QW-1:0] quo;
    } div_t;

    // dv: 0 = x edge shift, 1 = width loss, 2 = y edge shift, 3 = height loss
    typedef struct packed {
        status_t       status;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] sw;
        logic [CW-1:0] sh;
        logic [DW-1:0] dx;
        logic [DW-1:0] dy;
        logic [DW-1:0] dw;
        logic [DW-1:0] dh;
        logic [EW-1:0] divx;
        logic [EW-1:0] divy;
        div_t [3:0]    dv;
    } ctx_t;

    function automatic div_t div_step(div_t d, logic [EW-1:0] dvs, int b);
        div_t          r;
        logic [NW:0]   trial;
        r = d;
        trial = {1'b0, d.rem} - ({{(NW + 1 - EW){1'b0}}, dvs} << b);
        if (!trial[NW]) begin
            r.rem = trial[NW-1:0];
            r.quo[b] = 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- hdl/blit_rect_clip_and_scale_core.sv -----
// channel | ports             | direction | beat
// input   | s_valid / s_ready | in        | one copy request
// result  | m_valid / m_ready | out       | status, clipped source, scaled destination
// config  | cfg_valid / cfg_ready | in    | register index and write data
//
// Pipeline: 3 clip/multiply stages, 15 divider stages (one quotient bit each), 1 output
// register. One request per cycle sustained while the result side is not back-pressured.
// Each stage advances when it is empty or the stage after it advances, so bubbles fill
// under back-pressure. Config writes are accepted every cycle (cfg_ready high).
// Synchronous active-low reset clears the valid bits and loads register defaults.
module blit_rect_clip_and_scale_core
    import brc_pkg::*;
#(
    parameter int MAX_EXTENT = 16384
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_src_given,
    input  logic signed [15:0]   s_src_x,
    input  logic signed [15:0]   s_src_y,
    input  logic signed [15:0]   s_src_w,
    input  logic signed [15:0]   s_src_h,
    input  logic                 s_dst_given,
    input  logic signed [15:0]   s_dst_x,
    input  logic signed [15:0]   s_dst_y,
    input  logic signed [15:0]   s_dst_w,
    input  logic signed [15:0]   s_dst_h,
    input  logic [14:0]          s_tex_width,
    input  logic [14:0]          s_tex_height,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic signed [15:0]   m_out_src_x,
    output logic signed [15:0]   m_out_src_y,
    output logic signed [15:0]   m_out_src_w,
    output logic signed [15:0]   m_out_src_h,
    output logic [29:0]          m_out_dst_x,
    output logic [29:0]          m_out_dst_y,
    output logic [29:0]          m_out_dst_w,
    output logic [29:0]          m_out_dst_h
);

    cfg_t  cfg_reg;
    req_t  req;
    ctx_t  clip_ctx, div_ctx;
    logic  clip_valid, clip_ready, div_valid, div_ready;
    logic  adv_o;

    logic          mv_reg;
    status_t       st_reg, st_next;
    logic [CW-1:0] sx_reg, sy_reg, sw_reg, sh_reg;
    logic [CW-1:0] sx_next, sy_next, sw_next, sh_next;
    logic [DW-1:0] dx_reg, dy_reg, dw_reg, dh_reg;
    logic [DW-1:0] dx_next, dy_next, dw_next, dh_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.view_width  <= EW'(320);
            cfg_reg.view_height <= EW'(240);
            cfg_reg.scale_x     <= SW'(256);
            cfg_reg.scale_y     <= SW'(256);
            cfg_reg.hidden      <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_VIEW_WIDTH:  cfg_reg.view_width  <= cfg_wdata[EW-1:0];
                CFG_VIEW_HEIGHT: cfg_reg.view_height <= cfg_wdata[EW-1:0];
                CFG_SCALE_X:     cfg_reg.scale_x     <= cfg_wdata;
                CFG_SCALE_Y:     cfg_reg.scale_y     <= cfg_wdata;
                CFG_HIDDEN:      cfg_reg.hidden      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign req.src_given  = s_src_given;
    assign req.src_x      = s_src_x;
    assign req.src_y      = s_src_y;
    assign req.src_w      = s_src_w;
    assign req.src_h      = s_src_h;
    assign req.dst_given  = s_dst_given;
    assign req.dst_x      = s_dst_x;
    assign req.dst_y      = s_dst_y;
    assign req.dst_w      = s_dst_w;
    assign req.dst_h      = s_dst_h;
    assign req.tex_width  = s_tex_width;
    assign req.tex_height = s_tex_height;

    brc_clip #(
        .MAX_EXTENT(MAX_EXTENT)
    ) u_clip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .req       (req),
        .cfg       (cfg_reg),
        .out_valid (clip_valid),
        .out_ready (clip_ready),
        .ctx       (clip_ctx)
    );

    brc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (clip_valid),
        .in_ready  (clip_ready),
        .in_ctx    (clip_ctx),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_ctx   (div_ctx)
    );

    assign adv_o     = !mv_reg || m_ready;
    assign div_ready = adv_o;

    // quotients for edge shifts add, those for extent loss subtract
    always_comb begin
        st_next = div_ctx.status;
        if (div_ctx.status == ST_DRAW) begin
            sx_next = div_ctx.sx + {1'b0, div_ctx.dv[0].quo};
            sw_next = div_ctx.sw - {1'b0, div_ctx.dv[1].quo};
            sy_next = div_ctx.sy + {1'b0, div_ctx.dv[2].quo};
            sh_next = div_ctx.sh - {1'b0, div_ctx.dv[3].quo};
            dx_next = div_ctx.dx;
            dy_next = div_ctx.dy;
            dw_next = div_ctx.dw;
            dh_next = div_ctx.dh;
        end else begin
            sx_next = '0;
            sw_next = '0;
            sy_next = '0;
            sh_next = '0;
            dx_next = '0;
            dy_next = '0;
            dw_next = '0;
            dh_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (adv_o) begin
            mv_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_o && div_valid) begin
            st_reg <= st_next;
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            sw_reg <= sw_next;
            sh_reg <= sh_next;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            dw_reg <= dw_next;
            dh_reg <= dh_next;
        end
    end

    assign m_valid     = mv_reg;
    assign m_status    = st_reg;
    assign m_out_src_x = sx_reg;
    assign m_out_src_y = sy_reg;
    assign m_out_src_w = sw_reg;
    assign m_out_src_h = sh_reg;
    assign m_out_dst_x = dx_reg;
    assign m_out_dst_y = dy_reg;
    assign m_out_dst_w = dw_reg;
    assign m_out_dst_h = dh_reg;

    a_no_draw_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_DRAW) |->
            (m_out_src_w == 16'd0 && m_out_src_x == 16'd0 && m_out_dst_w == 30'd0
             && m_out_dst_h == 30'd0))
        else $error("non-draw result carries nonzero fields");

    a_stall_only_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output back-pressure");

    a_reset_empty: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_valid)
        else $error("result valid right after reset");

    a_cfg_always: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_index == CFG_HIDDEN) |=> (cfg_reg.hidden == $past(cfg_wdata[0])))
        else $error("hidden register not written");

endmodule

// ----- hdl/brc_clip.sv -----
module brc_clip
    import brc_pkg::*;
#(
    parameter int MAX_EXTENT = 16384
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  req_t req,
    input  cfg_t cfg,
    output logic out_valid,
    input  logic out_ready,
    output ctx_t ctx
);

    typedef struct packed {
        logic                 sg;
        logic                 dg;
        logic                 sbad;
        logic                 dbad;
        logic [CW-1:0]        slx;
        logic [CW-1:0]        sly;
        logic [CW-1:0]        dlx;
        logic [CW-1:0]        dly;
        logic signed [17:0]   shx;
        logic signed [17:0]   shy;
        logic signed [17:0]   dhx;
        logic signed [17:0]   dhy;
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
        logic signed [CW-1:0] rw;
        logic signed [CW-1:0] rh;
    } s1_t;

    typedef struct packed {
        status_t       st;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] sw;
        logic [CW-1:0] sh;
        logic [EW-1:0] dx;
        logic [EW-1:0] dy;
        logic [EW-1:0] dw;
        logic [EW-1:0] dh;
        logic [EW-1:0] mx;
        logic [EW-1:0] mw;
        logic [EW-1:0] my;
        logic [EW-1:0] mh;
        logic [EW-1:0] divx;
        logic [EW-1:0] divy;
    } s2_t;

    function automatic logic [EW-1:0] clamp_ext(logic [EW-1:0] v);
        return ({17'd0, v} > MAX_EXTENT) ? EW'(MAX_EXTENT) : v;
    endfunction

    function automatic logic signed [17:0] sx18(logic signed [CW-1:0] v);
        return {{2{v[CW-1]}}, v};
    endfunction

    function automatic logic [CW-1:0] lo0(logic signed [CW-1:0] v);
        return v[CW-1] ? '0 : v;
    endfunction

    function automatic logic signed [17:0] hi_min(logic signed [CW-1:0] p,
                                                  logic signed [CW-1:0] e,
                                                  logic [EW-1:0] lim);
        logic signed [17:0] s;
        logic signed [17:0] l;
        s = sx18(p) + sx18(e);
        l = {3'b000, lim};
        return (s < l) ? s : l;
    endfunction

    logic  v1_reg, v2_reg, v3_reg;
    logic  adv1, adv2, adv3;
    s1_t   s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    ctx_t  s3_reg, s3_next;

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb begin
        logic [EW-1:0] tw, th, vw, vh;
        tw = clamp_ext(req.tex_width);
        th = clamp_ext(req.tex_height);
        vw = clamp_ext(cfg.view_width);
        vh = clamp_ext(cfg.view_height);
        s1_next.sg   = req.src_given;
        s1_next.dg   = req.dst_given;
        s1_next.sbad = (req.src_w <= 0) || (req.src_h <= 0) || (tw == '0) || (th == '0);
        s1_next.dbad = (req.dst_w <= 0) || (req.dst_h <= 0) || (vw == '0) || (vh == '0);
        s1_next.rx   = req.dst_x;
        s1_next.ry   = req.dst_y;
        s1_next.rw   = req.dst_w;
        s1_next.rh   = req.dst_h;
        if (req.src_given) begin
            s1_next.slx = lo0(req.src_x);
            s1_next.sly = lo0(req.src_y);
            s1_next.shx = hi_min(req.src_x, req.src_w, tw);
            s1_next.shy = hi_min(req.src_y, req.src_h, th);
        end else begin
            s1_next.slx = '0;
            s1_next.sly = '0;
            s1_next.shx = {3'b000, tw};
            s1_next.shy = {3'b000, th};
        end
        if (req.dst_given) begin
            s1_next.dlx = lo0(req.dst_x);
            s1_next.dly = lo0(req.dst_y);
            s1_next.dhx = hi_min(req.dst_x, req.dst_w, vw);
            s1_next.dhy = hi_min(req.dst_y, req.dst_h, vh);
        end else begin
            s1_next.dlx = '0;
            s1_next.dly = '0;
            s1_next.dhx = {3'b000, vw};
            s1_next.dhy = {3'b000, vh};
        end
    end

    always_comb begin
        logic signed [17:0] sw, sh, dw, dh, ex, ey, lw, lh;
        logic               sfail, dfail;
        sw = s1_reg.shx - $signed({2'b00, s1_reg.slx});
        sh = s1_reg.shy - $signed({2'b00, s1_reg.sly});
        dw = s1_reg.dhx - $signed({2'b00, s1_reg.dlx});
        dh = s1_reg.dhy - $signed({2'b00, s1_reg.dly});
        ex = $signed({2'b00, s1_reg.dlx}) - sx18(s1_reg.rx);
        ey = $signed({2'b00, s1_reg.dly}) - sx18(s1_reg.ry);
        lw = sx18(s1_reg.rw) - dw;
        lh = sx18(s1_reg.rh) - dh;
        sfail = s1_reg.sg && (s1_reg.sbad || (sw <= 0) || (sh <= 0));
        dfail = s1_reg.dg && (s1_reg.dbad || (dw <= 0) || (dh <= 0));
        priority if (sfail) s2_next.st = ST_SRC_EMPTY;
        else if (dfail)     s2_next.st = ST_DST_EMPTY;
        else if (cfg.hidden) s2_next.st = ST_HIDDEN;
        else                s2_next.st = ST_DRAW;
        s2_next.sx = s1_reg.slx;
        s2_next.sy = s1_reg.sly;
        s2_next.sw = sw[CW-1:0];
        s2_next.sh = sh[CW-1:0];
        s2_next.dx = s1_reg.dlx[EW-1:0];
        s2_next.dy = s1_reg.dly[EW-1:0];
        s2_next.dw = dw[EW-1:0];
        s2_next.dh = dh[EW-1:0];
        if (s1_reg.dg) begin
            s2_next.mx   = ex[EW-1:0];
            s2_next.my   = ey[EW-1:0];
            s2_next.mw   = lw[EW-1:0];
            s2_next.mh   = lh[EW-1:0];
            s2_next.divx = s1_reg.rw[EW-1:0];
            s2_next.divy = s1_reg.rh[EW-1:0];
        end else begin
            s2_next.mx   = '0;
            s2_next.my   = '0;
            s2_next.mw   = '0;
            s2_next.mh   = '0;
            s2_next.divx = EW'(1);
            s2_next.divy = EW'(1);
        end
    end

    function automatic logic [DW-1:0] scale_sat(logic [EW-1:0] v, logic [SW-1:0] s);
        logic [EW+SW-1:0] p;
        p = v * s;
        return (p > {{(EW + SW - DW){1'b0}}, {DW{1'b1}}}) ? {DW{1'b1}} : p[DW-1:0];
    endfunction

    always_comb begin
        s3_next.status = s2_reg.st;
        s3_next.sx     = s2_reg.sx;
        s3_next.sy     = s2_reg.sy;
        s3_next.sw     = s2_reg.sw;
        s3_next.sh     = s2_reg.sh;
        s3_next.dx     = scale_sat(s2_reg.dx, cfg.scale_x);
        s3_next.dy     = scale_sat(s2_reg.dy, cfg.scale_y);
        s3_next.dw     = scale_sat(s2_reg.dw, cfg.scale_x);
        s3_next.dh     = scale_sat(s2_reg.dh, cfg.scale_y);
        s3_next.divx   = s2_reg.divx;
        s3_next.divy   = s2_reg.divy;
        s3_next.dv[0].rem = s2_reg.mx * s2_reg.sw[EW-1:0];
        s3_next.dv[1].rem = s2_reg.mw * s2_reg.sw[EW-1:0];
        s3_next.dv[2].rem = s2_reg.my * s2_reg.sh[EW-1:0];
        s3_next.dv[3].rem = s2_reg.mh * s2_reg.sh[EW-1:0];
        s3_next.dv[0].quo = '0;
        s3_next.dv[1].quo = '0;
        s3_next.dv[2].quo = '0;
        s3_next.dv[3].quo = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) s1_reg <= s1_next;
        if (adv2 && v1_reg)   s2_reg <= s2_next;
        if (adv3 && v2_reg)   s3_reg <= s3_next;
    end

    assign out_valid = v3_reg;
    assign ctx       = s3_reg;

endmodule

// ----- hdl/brc_div.sv -----
module brc_div
    import brc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  ctx_t in_ctx,
    output logic out_valid,
    input  logic out_ready,
    output ctx_t out_ctx
);

    logic [QW-1:0] v_reg;
    logic [QW-1:0] adv;
    logic [QW-1:0] up_v;
    ctx_t          stg_reg  [QW];
    ctx_t          stg_next [QW];
    ctx_t          up_ctx   [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        if (i == 0) begin : g_first
            assign up_ctx[i] = in_ctx;
            assign up_v[i]   = in_valid;
        end else begin : g_next
            assign up_ctx[i] = stg_reg[i-1];
            assign up_v[i]   = v_reg[i-1];
        end
        if (i == QW - 1) begin : g_last
            assign adv[i] = !v_reg[i] || out_ready;
        end else begin : g_mid
            assign adv[i] = !v_reg[i] || adv[i+1];
        end

        always_comb begin
            stg_next[i] = up_ctx[i];
            stg_next[i].dv[0] = div_step(up_ctx[i].dv[0], up_ctx[i].divx, QW - 1 - i);
            stg_next[i].dv[1] = div_step(up_ctx[i].dv[1], up_ctx[i].divx, QW - 1 - i);
            stg_next[i].dv[2] = div_step(up_ctx[i].dv[2], up_ctx[i].divy, QW - 1 - i);
            stg_next[i].dv[3] = div_step(up_ctx[i].dv[3], up_ctx[i].divy, QW - 1 - i);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (adv[i]) begin
                v_reg[i] <= up_v[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[i] && up_v[i]) stg_reg[i] <= stg_next[i];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[QW-1];
    assign out_ctx   = stg_reg[QW-1];

endmodule

// ----- dv/blit_clip_checker.sv -----
module blit_clip_checker
    import brc_pkg::*;
#(
    parameter int MAX_EXTENT = 16384
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  req_t               s_req,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_status,
    input  logic signed [15:0] m_out_src_x,
    input  logic signed [15:0] m_out_src_y,
    input  logic signed [15:0] m_out_src_w,
    input  logic signed [15:0] m_out_src_h,
    input  logic [29:0]        m_out_dst_x,
    input  logic [29:0]        m_out_dst_y,
    input  logic [29:0]        m_out_dst_w,
    input  logic [29:0]        m_out_dst_h,
    output int                 errors,
    output int                 pending,
    output int                 results,
    output int                 drawn
);

    typedef struct {
        status_t       status;
        logic [15:0]   sx, sy, sw, sh;
        logic [29:0]   dx, dy, dw, dh;
    } blit_out_t;

    blit_out_t expected_blits[$];

    logic [14:0] view_w, view_h;
    logic [15:0] zoom_x, zoom_y;
    logic        hide;

    assign pending = expected_blits.size();

    function automatic longint clamp_ext(logic [14:0] v);
        return (v > MAX_EXTENT) ? longint'(MAX_EXTENT) : longint'(v);
    endfunction

    function automatic bit overlap(longint ax, ay, aw, ah, bx, by, bw, bh,
                                   output longint rx, ry, rw, rh);
        longint lo, hi;
        if (aw <= 0 || ah <= 0 || bw <= 0 || bh <= 0)
            return 0;
        lo = (ax > bx) ? ax : bx;
        hi = (ax + aw < bx + bw) ? ax + aw : bx + bw;
        rx = lo;
        rw = hi - lo;
        lo = (ay > by) ? ay : by;
        hi = (ay + ah < by + bh) ? ay + ah : by + bh;
        ry = lo;
        rh = hi - lo;
        return !(rw <= 0 || rh <= 0);
    endfunction

    function automatic logic [29:0] scaled_dst(longint v, longint s);
        longint p;
        if (v <= 0)
            return '0;
        p = v * s;
        return (p > 64'h3FFF_FFFF) ? 30'h3FFF_FFFF : p[29:0];
    endfunction

    function automatic blit_out_t clip_and_scale(req_t r);
        blit_out_t o;
        longint sx, sy, sw, sh, dx, dy, dw, dh;
        longint qx, qy, qw, qh, tx, ty, tw, th;
        o = '{status: ST_DRAW, default: '0};
        sx = 0;
        sy = 0;
        sw = clamp_ext(r.tex_width);
        sh = clamp_ext(r.tex_height);
        if (r.src_given) begin
            if (!overlap(r.src_x, r.src_y, r.src_w, r.src_h, sx, sy, sw, sh,
                         tx, ty, tw, th)) begin
                o.status = ST_SRC_EMPTY;
                return o;
            end
            sx = tx; sy = ty; sw = tw; sh = th;
        end
        dx = 0;
        dy = 0;
        dw = clamp_ext(view_w);
        dh = clamp_ext(view_h);
        if (r.dst_given) begin
            qx = r.dst_x; qy = r.dst_y; qw = r.dst_w; qh = r.dst_h;
            if (!overlap(qx, qy, qw, qh, dx, dy, dw, dh, tx, ty, tw, th)) begin
                o.status = ST_DST_EMPTY;
                return o;
            end
            dx = tx; dy = ty; dw = tw; dh = th;
            // source edges follow destination clipping proportionally
            if (qw != dw) begin
                tx = sw;
                sx += ((dx - qx) * tx) / qw;
                sw += ((dw - qw) * tx) / qw;
            end
            if (qh != dh) begin
                ty = sh;
                sy += ((dy - qy) * ty) / qh;
                sh += ((dh - qh) * ty) / qh;
            end
        end
        if (hide) begin
            o.status = ST_HIDDEN;
            return o;
        end
        o.sx = sx[15:0];
        o.sy = sy[15:0];
        o.sw = sw[15:0];
        o.sh = sh[15:0];
        o.dx = scaled_dst(dx, zoom_x);
        o.dy = scaled_dst(dy, zoom_y);
        o.dw = scaled_dst(dw, zoom_x);
        o.dh = scaled_dst(dh, zoom_y);
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    initial begin
        errors = 0;
        results = 0;
        drawn = 0;
    end

    always @(posedge aclk) begin
        blit_out_t e;
        if (!aresetn) begin
            view_w <= 15'd320;
            view_h <= 15'd240;
            zoom_x <= 16'd256;
            zoom_y <= 16'd256;
            hide   <= 1'b0;
            expected_blits.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_VIEW_WIDTH:  view_w <= cfg_wdata[14:0];
                    CFG_VIEW_HEIGHT: view_h <= cfg_wdata[14:0];
                    CFG_SCALE_X:     zoom_x <= cfg_wdata;
                    CFG_SCALE_Y:     zoom_y <= cfg_wdata;
                    CFG_HIDDEN:      hide   <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_blits.push_back(clip_and_scale(s_req));
            if (m_valid && m_ready) begin
                results++;
                if (expected_blits.size() == 0) begin
                    report_mismatch("unexpected beat", m_status, 0);
                end else begin
                    e = expected_blits.pop_front();
                    if (e.status == ST_DRAW)
                        drawn++;
                    if (m_status != e.status)
                        report_mismatch("status", m_status, e.status);
                    if (m_out_src_x != e.sx) report_mismatch("src_x", m_out_src_x, e.sx);
                    if (m_out_src_y != e.sy) report_mismatch("src_y", m_out_src_y, e.sy);
                    if (m_out_src_w != e.sw) report_mismatch("src_w", m_out_src_w, e.sw);
                    if (m_out_src_h != e.sh) report_mismatch("src_h", m_out_src_h, e.sh);
                    if (m_out_dst_x != e.dx) report_mismatch("dst_x", m_out_dst_x, e.dx);
                    if (m_out_dst_y != e.dy) report_mismatch("dst_y", m_out_dst_y, e.dy);
                    if (m_out_dst_w != e.dw) report_mismatch("dst_w", m_out_dst_w, e.dw);
                    if (m_out_dst_h != e.dh) report_mismatch("dst_h", m_out_dst_h, e.dh);
                end
            end
        end
    end

endmodule

// ----- dv/tb_top.sv -----
module tb_top
    import brc_pkg::*;
();

    localparam int IDLE_LIMIT = 5000;
    localparam int PER_PHASE  = 186;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_req = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_status;
    logic signed [15:0] m_out_src_x, m_out_src_y, m_out_src_w, m_out_src_h;
    logic [29:0] m_out_dst_x, m_out_dst_y, m_out_dst_w, m_out_dst_h;

    int errors, pending, results, drawn;
    bit fast;
    bit hold_off;
    int sent;
    int idle_cycles;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    blit_rect_clip_and_scale_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_src_given(s_req.src_given), .s_src_x(s_req.src_x), .s_src_y(s_req.src_y),
        .s_src_w(s_req.src_w), .s_src_h(s_req.src_h),
        .s_dst_given(s_req.dst_given), .s_dst_x(s_req.dst_x), .s_dst_y(s_req.dst_y),
        .s_dst_w(s_req.dst_w), .s_dst_h(s_req.dst_h),
        .s_tex_width(s_req.tex_width), .s_tex_height(s_req.tex_height),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_out_src_x(m_out_src_x), .m_out_src_y(m_out_src_y),
        .m_out_src_w(m_out_src_w), .m_out_src_h(m_out_src_h),
        .m_out_dst_x(m_out_dst_x), .m_out_dst_y(m_out_dst_y),
        .m_out_dst_w(m_out_dst_w), .m_out_dst_h(m_out_dst_h)
    );

    blit_clip_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_out_src_x(m_out_src_x), .m_out_src_y(m_out_src_y),
        .m_out_src_w(m_out_src_w), .m_out_src_h(m_out_src_h),
        .m_out_dst_x(m_out_dst_x), .m_out_dst_y(m_out_dst_y),
        .m_out_dst_w(m_out_dst_w), .m_out_dst_h(m_out_dst_h),
        .errors(errors), .pending(pending), .results(results), .drawn(drawn)
    );

    // watchdog: cycles with no beat on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end else begin
                stall = fast ? 0 : $urandom_range(0, 9);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    function automatic req_t blit(bit sg, int sx, int sy, int sw, int sh,
                                  bit dg, int dx, int dy, int dw, int dh,
                                  int tw, int th);
        req_t r;
        r.src_given = sg;
        r.src_x = 16'(sx); r.src_y = 16'(sy); r.src_w = 16'(sw); r.src_h = 16'(sh);
        r.dst_given = dg;
        r.dst_x = 16'(dx); r.dst_y = 16'(dy); r.dst_w = 16'(dw); r.dst_h = 16'(dh);
        r.tex_width = 15'(tw);
        r.tex_height = 15'(th);
        return r;
    endfunction

    function automatic logic [15:0] rand_coord(bit wide);
        return wide ? 16'($urandom) : 16'($urandom_range(0, 1100) - 300);
    endfunction

    function automatic req_t rand_blit();
        req_t r;
        bit wide;
        wide = ($urandom_range(0, 9) < 2);
        r.src_given = ($urandom_range(0, 3) != 0);
        r.dst_given = ($urandom_range(0, 3) != 0);
        r.src_x = rand_coord(wide);
        r.src_y = rand_coord(wide);
        r.src_w = rand_coord(wide);
        r.src_h = rand_coord(wide);
        r.dst_x = rand_coord(wide);
        r.dst_y = rand_coord(wide);
        r.dst_w = rand_coord(wide);
        r.dst_h = rand_coord(wide);
        r.tex_width  = ($urandom_range(0, 7) == 0) ? 15'($urandom_range(1, 16384))
                                                   : 15'($urandom_range(1, 640));
        r.tex_height = ($urandom_range(0, 7) == 0) ? 15'($urandom_range(1, 16384))
                                                   : 15'($urandom_range(1, 640));
        return r;
    endfunction

    task automatic send_blit(req_t r);
        int gap;
        gap = fast ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_req   <= r;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (25) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
    endtask

    task automatic load_view(int vw, int vh, int zx, int zy, bit hid);
        write_reg(CFG_VIEW_WIDTH, 16'(vw));
        write_reg(CFG_VIEW_HEIGHT, 16'(vh));
        write_reg(CFG_SCALE_X, 16'(zx));
        write_reg(CFG_SCALE_Y, 16'(zy));
        write_reg(CFG_HIDDEN, 16'(hid));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int ph;
        sent = 0;
        idle_cycles = 0;
        fast = 0;
        hold_off = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset settings
        send_blit(blit(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 64, 32));
        send_blit(blit(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16384, 16384));
        send_blit(blit(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
        send_blit(blit(1, 10, 10, 20, 20, 0, 0, 0, 0, 0, 64, 64));
        send_blit(blit(1, 0, 0, 0, 5, 0, 0, 0, 0, 0, 64, 64));
        send_blit(blit(1, 0, 0, 5, -1, 0, 0, 0, 0, 0, 64, 64));
        send_blit(blit(1, 64, 0, 5, 5, 0, 0, 0, 0, 0, 64, 64));
        send_blit(blit(1, -32768, -32768, 32767, 32767, 0, 0, 0, 0, 0, 100, 100));
        send_blit(blit(1, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0, 16384, 16384));
        send_blit(blit(1, -32768, -32768, -32768, -32768, 1, 0, 0, 10, 10, 64, 64));
        send_blit(blit(0, 0, 0, 0, 0, 1, -50, -30, 100, 100, 64, 64));
        send_blit(blit(0, 0, 0, 0, 0, 1, 300, 200, 100, 100, 77, 33));
        send_blit(blit(1, 3, 5, 17, 29, 1, -7, 230, 31, 13, 64, 64));
        send_blit(blit(0, 0, 0, 0, 0, 1, 320, 0, 10, 10, 64, 64));
        send_blit(blit(0, 0, 0, 0, 0, 1, 0, 0, 0, 10, 64, 64));
        send_blit(blit(0, 0, 0, 0, 0, 1, -32768, -32768, 32767, 32767, 16384, 16384));
        send_blit(blit(0, 0, 0, 0, 0, 1, 32767, 32767, -1, -1, 64, 64));
        send_blit(blit(1, 100, 0, 10, 10, 1, 400, 0, 10, 10, 64, 64));
        send_blit(blit(0, 0, 0, 0, 0, 1, -1, -1, 322, 242, 16383, 16383));
        send_blit(blit(1, 0, 0, 16384, 16384, 1, 0, 0, 320, 240, 16384, 16384));
        drain();

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: load_view(1, 1, 1, 1, 0);
                1: load_view(16384, 16384, 65535, 65535, 0);
                2: load_view(320, 240, 256, 256, 1);
                3: load_view($urandom_range(1, 16384), $urandom_range(1, 1024),
                             $urandom_range(1, 65535), $urandom_range(1, 65535), 0);
                default: load_view(640, 480, 384, 128, 0);
            endcase
            fast = (ph == 3);
            if (ph == 1) begin
                // saturation and the extreme coordinates at max scale
                send_blit(blit(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16384, 16384));
                send_blit(blit(0, 0, 0, 0, 0, 1, 16000, 16000, 32767, 32767, 9, 9));
            end
            if (ph == 4) begin
                hold_off = 1;
                fast = 1;
                repeat (60) send_blit(rand_blit());
                fast = 0;
            end
            repeat (PER_PHASE - ((ph == 4) ? 60 : 0)) send_blit(rand_blit());
            drain();
        end

        $display("Sent %0d copy requests over 6 register settings (incl. hidden and max scale)",
                 sent);
        $display("Checked %0d results, %0d of them drawn, %0d still waiting",
                 results, drawn, pending);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
